>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the beat detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is held.
`define PBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that a condition never holds outside of reset.
`define PBD_ASSERT_NEVER(lbl, expr, msg) \
  `PBD_ASSERT(lbl, !(expr), msg)

`endif

>>> sv/pbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_pkg
// Types and constants shared by the pulse beat detector modules.
// ----------------------------------------------------------------------------
package pbd_pkg;

  // Field and state widths.
  localparam int SAMPLE_W   = 10;
  localparam int ELAPSED_W  = 10;
  localparam int LEVEL_W    = 10;
  localparam int INTERVAL_W = 20;
  localparam int BPM_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MS_W       = 16;

  // Saturation value of the time counter.
  localparam logic [INTERVAL_W-1:0] TIME_MAX = '1;

  // Beat interval after reset, and the refractory gate that follows from it.
  localparam logic [INTERVAL_W-1:0] START_INTERVAL = 20'd600;
  localparam logic [INTERVAL_W-1:0] START_GATE     = 20'd360;

  // Dividend of the rate division.
  localparam logic [BPM_W-1:0] MS_PER_MINUTE = 16'd60000;

  // floor(x / 5) = (x * RECIP_FIVE) >> RECIP_SHIFT, exact for x below 2^22.
  localparam logic [INTERVAL_W-1:0] RECIP_FIVE = 20'd838861;
  localparam int RECIP_SHIFT = 22;

  // Register reset values.
  localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 10'd512;
  localparam logic [MS_W-1:0]    MIN_MS_RESET  = 16'd250;
  localparam logic [MS_W-1:0]    MAX_MS_RESET  = 16'd2500;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEF_THRESHOLD = 3'd0,
    CFG_DEF_PEAK      = 3'd1,
    CFG_DEF_TROUGH    = 3'd2,
    CFG_MIN_INTERVAL  = 3'd3,
    CFG_MAX_INTERVAL  = 3'd4
  } cfg_idx_t;

  // Per-cycle control of the interval history chain.
  typedef struct packed {
    logic load_all;  // every cell takes the fill value
    logic shift;     // every cell takes its neighbor's value
  } cell_ctrl_t;

endpackage

>>> sv/pulse_beat_detector_bpm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_beat_detector_bpm
// Pulse beat detector: adaptive threshold, beat timing and BPM estimate.
// ----------------------------------------------------------------------------
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+----------------------
//  in      | in_sample, in_elapsed_ms                | in_valid & in_ready
//  out     | out_bpm, out_beat, out_pulse_high       | out_valid & out_ready
//  cfg     | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
//  A sample without a new rate goes through S_EMIT to the output register,
//  which takes it once it is free. A beat that updates the rate first sums
//  the history chain in one rotation, then takes the mean by reciprocal
//  multiply, then runs the one-bit-per-cycle rate division. One sample is
//  worked at a time; a result waiting in the output register does not stop
//  the next transfer, but that sample's result waits for out_ready.
//  cfg_ready is always high. Synchronous reset restores the configuration
//  registers and detector state at once, not the work and output data.
// ----------------------------------------------------------------------------
module pulse_beat_detector_bpm #(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pbd_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic [pbd_pkg::ELAPSED_W-1:0]     in_elapsed_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pbd_pkg::BPM_W-1:0]         out_bpm,
  output logic                              out_beat,
  output logic                              out_pulse_high,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IW         = pbd_pkg::INTERVAL_W;
  localparam int LW         = pbd_pkg::LEVEL_W;
  localparam int BW         = pbd_pkg::BPM_W;
  localparam int SUM_W      = IW + $clog2(HISTORY_DEPTH);
  localparam int DIV_STEP_W = $clog2(BW + 1);
  localparam int ROT_W      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // floor(sum / HISTORY_DEPTH) = (sum * MEAN_RECIP) >> MEAN_SHIFT for every
  // sum below 2^SUM_W.
  localparam int MEAN_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
  localparam logic [SUM_W:0] MEAN_RECIP = (SUM_W + 1)'(
    ((64'd1 << MEAN_SHIFT) + 64'(HISTORY_DEPTH - 1)) / 64'(HISTORY_DEPTH));

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MEAN,
    S_RATE,
    S_BPM_WAIT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [LW-1:0]            def_thr_r, def_thr_nxt;
  logic [LW-1:0]            def_peak_r, def_peak_nxt;
  logic [LW-1:0]            def_trough_r, def_trough_nxt;
  logic [pbd_pkg::MS_W-1:0] min_ms_r, min_ms_nxt;
  logic [pbd_pkg::MS_W-1:0] max_ms_r, max_ms_nxt;

  // Detector state.
  logic [IW-1:0]  since_r, since_nxt;
  logic [IW-1:0]  interval_r, interval_nxt;
  logic [IW-1:0]  gate_r, gate_nxt;
  logic [LW-1:0]  peak_r, peak_nxt;
  logic [LW-1:0]  trough_r, trough_nxt;
  logic [LW-1:0]  thr_r, thr_nxt;
  logic           in_pulse_r, in_pulse_nxt;
  logic           first_r, first_nxt;
  logic           second_r, second_nxt;
  logic [BW-1:0]  bpm_r, bpm_nxt;

  // Work registers of one sample.
  logic              beat_r, beat_nxt;
  logic              upd_r, upd_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [ROT_W-1:0]  rot_r, rot_nxt;
  logic [IW-1:0]     mean_r, mean_nxt;

  // Output register.
  logic           out_valid_r, out_valid_nxt;
  logic [BW-1:0]  out_bpm_r, out_bpm_nxt;
  logic           out_beat_r, out_beat_nxt;
  logic           out_pulse_r, out_pulse_nxt;

  // Per-sample evaluation.
  logic [IW:0]        since_sum;
  logic [IW-1:0]      n_ms;
  logic               above, below, past_gate, is_beat, timeout;
  logic [LW-1:0]      peak1, trough1;
  logic signed [LW:0] diff, half, mid;

  // Refractory gate: (interval / 5) * 3 through a reciprocal multiply.
  logic [2*IW-1:0]    recip_prod;
  logic [IW-1:0]      fifth;

  // Mean of the history through a reciprocal multiply.
  logic [2*SUM_W:0]   mean_prod;

  // History chain and divider.
  pbd_pkg::cell_ctrl_t   cell_ctrl;
  logic [IW-1:0]         tail_in;
  logic [IW-1:0]         cell_q [HISTORY_DEPTH];
  logic                  div_start, div_busy;
  logic [BW-1:0]         div_quo;
  logic [IW-1:0]         div_divisor;

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;

  // Gate follows the registered beat interval in the next cycle, before the next sample.
  always_comb begin
    recip_prod = interval_r * pbd_pkg::RECIP_FIVE;
    fifth      = IW'(recip_prod[2*IW-1:pbd_pkg::RECIP_SHIFT]);
    gate_nxt   = {fifth[IW-2:0], 1'b0} + fifth;
  end

  // The accumulated sum times the reciprocal of the depth.
  always_comb begin
    mean_prod = (2*SUM_W + 1)'(acc_r) * (2*SUM_W + 1)'(MEAN_RECIP);
  end

  // Sample evaluation: time, level tracking, beat test, timeout and pulse end.
  always_comb begin
    since_sum = {1'b0, since_r} + (IW + 1)'(in_elapsed_ms);
    n_ms      = since_sum[IW] ? pbd_pkg::TIME_MAX : since_sum[IW-1:0];
    above     = in_sample > thr_r;
    below     = in_sample < thr_r;
    past_gate = n_ms > gate_r;
    trough1   = (below && past_gate && in_sample < trough_r) ? in_sample : trough_r;
    peak1     = (above && in_sample > peak_r) ? in_sample : peak_r;
    is_beat   = n_ms > IW'(min_ms_r) && above && !in_pulse_r && past_gate;
    timeout   = n_ms > IW'(max_ms_r);
    diff      = $signed({1'b0, peak1}) - $signed({1'b0, trough1});
    half      = $signed(diff + $signed({{LW{1'b0}}, diff[LW]})) >>> 1;
    mid       = $signed({1'b0, trough1}) + half;
  end

  // Configuration writes.
  always_comb begin
    def_thr_nxt    = def_thr_r;
    def_peak_nxt   = def_peak_r;
    def_trough_nxt = def_trough_r;
    min_ms_nxt     = min_ms_r;
    max_ms_nxt     = max_ms_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        pbd_pkg::CFG_DEF_THRESHOLD: def_thr_nxt    = cfg_data[LW-1:0];
        pbd_pkg::CFG_DEF_PEAK:      def_peak_nxt   = cfg_data[LW-1:0];
        pbd_pkg::CFG_DEF_TROUGH:    def_trough_nxt = cfg_data[LW-1:0];
        pbd_pkg::CFG_MIN_INTERVAL:  min_ms_nxt     = cfg_data;
        pbd_pkg::CFG_MAX_INTERVAL:  max_ms_nxt     = cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: sample update, history rotation, mean, rate division and result emission.
  always_comb begin
    state_nxt     = state_r;
    since_nxt     = since_r;
    interval_nxt  = interval_r;
    peak_nxt      = peak_r;
    trough_nxt    = trough_r;
    thr_nxt       = thr_r;
    in_pulse_nxt  = in_pulse_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    bpm_nxt       = bpm_r;
    beat_nxt      = beat_r;
    upd_nxt       = upd_r;
    acc_nxt       = acc_r;
    rot_nxt       = rot_r;
    mean_nxt      = mean_r;
    out_valid_nxt = out_valid_r;
    out_bpm_nxt   = out_bpm_r;
    out_beat_nxt  = out_beat_r;
    out_pulse_nxt = out_pulse_r;
    cell_ctrl     = '0;
    tail_in       = cell_q[0];
    div_start     = 1'b0;
    div_divisor   = mean_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          since_nxt  = n_ms;
          peak_nxt   = peak1;
          trough_nxt = trough1;
          beat_nxt   = is_beat;
          upd_nxt    = !timeout;
          state_nxt  = S_EMIT;
          if (is_beat) begin
            in_pulse_nxt = 1'b1;
            interval_nxt = n_ms;
            since_nxt    = '0;
            if (first_r) begin
              first_nxt  = 1'b0;
              second_nxt = 1'b1;
            end else begin
              // Shift the new interval in; the second beat fills every cell.
              second_nxt         = 1'b0;
              cell_ctrl.shift    = 1'b1;
              cell_ctrl.load_all = second_r;
              tail_in            = n_ms;
              acc_nxt            = '0;
              rot_nxt            = '0;
              state_nxt          = S_SUM;
            end
          end
          if (!(is_beat && first_r)) begin
            if (below && in_pulse_r) begin
              in_pulse_nxt = 1'b0;
              thr_nxt      = mid[LW-1:0];
              peak_nxt     = mid[LW-1:0];
              trough_nxt   = mid[LW-1:0];
            end
            if (timeout) begin
              thr_nxt    = def_thr_r;
              peak_nxt   = def_peak_r;
              trough_nxt = def_trough_r;
              since_nxt  = '0;
              first_nxt  = 1'b1;
              second_nxt = 1'b0;
              bpm_nxt    = '0;
            end
          end
        end
      end
      S_SUM: begin
        // Rotate the chain once around, adding each entry as it leaves the head.
        cell_ctrl.shift = 1'b1;
        acc_nxt         = acc_r + SUM_W'(cell_q[0]);
        if (rot_r == ROT_W'(HISTORY_DEPTH - 1)) begin
          state_nxt = S_MEAN;
        end else begin
          rot_nxt = rot_r + 1'b1;
        end
      end
      S_MEAN: begin
        mean_nxt  = mean_prod[MEAN_SHIFT +: IW];
        state_nxt = S_RATE;
      end
      S_RATE: begin
        if (mean_r == '0) begin
          if (upd_r) begin
            bpm_nxt = '0;
          end
          state_nxt = S_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_BPM_WAIT;
        end
      end
      S_BPM_WAIT: begin
        if (!div_busy) begin
          if (upd_r) begin
            bpm_nxt = div_quo;
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_bpm_nxt   = bpm_r;
          out_beat_nxt  = beat_r;
          out_pulse_nxt = in_pulse_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      def_thr_r    <= pbd_pkg::LEVEL_RESET;
      def_peak_r   <= pbd_pkg::LEVEL_RESET;
      def_trough_r <= pbd_pkg::LEVEL_RESET;
      min_ms_r     <= pbd_pkg::MIN_MS_RESET;
      max_ms_r     <= pbd_pkg::MAX_MS_RESET;
      since_r      <= '0;
      interval_r   <= pbd_pkg::START_INTERVAL;
      gate_r       <= pbd_pkg::START_GATE;
      peak_r       <= pbd_pkg::LEVEL_RESET;
      trough_r     <= pbd_pkg::LEVEL_RESET;
      thr_r        <= pbd_pkg::LEVEL_RESET;
      in_pulse_r   <= 1'b0;
      first_r      <= 1'b1;
      second_r     <= 1'b0;
      bpm_r        <= '0;
      rot_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      def_thr_r    <= def_thr_nxt;
      def_peak_r   <= def_peak_nxt;
      def_trough_r <= def_trough_nxt;
      min_ms_r     <= min_ms_nxt;
      max_ms_r     <= max_ms_nxt;
      since_r      <= since_nxt;
      interval_r   <= interval_nxt;
      gate_r       <= gate_nxt;
      peak_r       <= peak_nxt;
      trough_r     <= trough_nxt;
      thr_r        <= thr_nxt;
      in_pulse_r   <= in_pulse_nxt;
      first_r      <= first_nxt;
      second_r     <= second_nxt;
      bpm_r        <= bpm_nxt;
      rot_r        <= rot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    beat_r      <= beat_nxt;
    upd_r       <= upd_nxt;
    acc_r       <= acc_nxt;
    mean_r      <= mean_nxt;
    out_bpm_r   <= out_bpm_nxt;
    out_beat_r  <= out_beat_nxt;
    out_pulse_r <= out_pulse_nxt;
  end

  // Interval history: cell 0 is the oldest entry, the tail takes new data.
  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_hist
    logic [IW-1:0] nb;
    if (g == HISTORY_DEPTH - 1) begin : g_tail
      assign nb = tail_in;
    end else begin : g_body
      assign nb = cell_q[g + 1];
    end
    pbd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .fill_value (tail_in),
      .neighbor   (nb),
      .value      (cell_q[g])
    );
  end

  // Rate divider: 60000 over the mean interval, one bit per cycle.
  pbd_div #(
    .DIVIDEND_W (BW),
    .DIVISOR_W  (IW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pbd_pkg::MS_PER_MINUTE),
    .divisor  (div_divisor),
    .steps    (DIV_STEP_W'(BW)),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign out_valid      = out_valid_r;
  assign out_bpm        = out_bpm_r;
  assign out_beat       = out_beat_r;
  assign out_pulse_high = out_pulse_r;

endmodule

>>> sv/pbd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_cell
// One entry of the beat interval history; hands its value down the chain.
// ----------------------------------------------------------------------------
module pbd_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pbd_pkg::cell_ctrl_t                ctrl,
  input  logic [pbd_pkg::INTERVAL_W-1:0]     fill_value,
  input  logic [pbd_pkg::INTERVAL_W-1:0]     neighbor,
  output logic [pbd_pkg::INTERVAL_W-1:0]     value
);

  logic [pbd_pkg::INTERVAL_W-1:0] value_r;
  logic [pbd_pkg::INTERVAL_W-1:0] value_nxt;

  // A fill wins over a shift; otherwise the entry holds.
  always_comb begin
    value_nxt = value_r;
    if (ctrl.load_all) begin
      value_nxt = fill_value;
    end else if (ctrl.shift) begin
      value_nxt = neighbor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
    end else begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

>>> sv/pbd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_div
// Restoring divider, one quotient bit per cycle, quotient MSB first.
// ----------------------------------------------------------------------------
module pbd_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 20,
  localparam int STEP_W    = $clog2(DIVIDEND_W + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  input  logic [STEP_W-1:0]     steps,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;

  // Load on start, else one trial subtraction of the shifted remainder.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVIDEND_W-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (start) begin
      cnt_nxt = steps;
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      rem_nxt = fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = cnt_r != '0;
  assign quotient = quo_r;

endmodule

>>> sv/pbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_checker
// Port-level checks of the pulse beat detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pbd_pkg::BPM_W-1:0]     out_bpm,
  input logic                          out_beat,
  input logic                          out_pulse_high,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  logic [1:0] pend_r;
  logic [1:0] pend_nxt;

  // Samples taken whose results have not been transferred yet.
  always_comb begin
    pend_nxt = pend_r;
    if (in_valid && in_ready) begin
      pend_nxt = pend_nxt + 2'd1;
    end
    if (out_valid && out_ready) begin
      pend_nxt = pend_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `PBD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_bpm) && $stable(out_beat) && $stable(out_pulse_high), "stalled result changed")
  `PBD_ASSERT(a_beat_in_pulse, out_valid && out_beat |-> out_pulse_high, "beat outside a pulse")
  `PBD_ASSERT(a_bpm_range, out_valid |-> out_bpm <= pbd_pkg::MS_PER_MINUTE, "rate out of range")
  `PBD_ASSERT_NEVER(a_no_extra, out_valid && pend_r == 2'd0, "result without a sample")
  `PBD_ASSERT(a_cfg_taken, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind pulse_beat_detector_bpm pbd_checker u_pbd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_bpm        (out_bpm),
  .out_beat       (out_beat),
  .out_pulse_high (out_pulse_high),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
